### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the hash dictionary.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LPHD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define LPHD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### hw/rtl/lphd_pkg.sv
// Types, codes and constants of the linear probing hash dictionary.
// Used by lphd_if, lphd_hash and the top level; depends on nothing.
package lphd_pkg;

  localparam int unsigned SlotsDefault    = 256;
  localparam int unsigned KeyBytesDefault = 8;
  localparam logic [8:0]  TableSizeReset  = 9'd251;
  localparam logic [31:0] HashMul         = 32'd25;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_GET   = 2'd1,
    OP_UNSET = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [63:0]        key;
    logic [3:0]         key_length;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_out;
    logic [7:0]         slot;
  } rsp_t;

endpackage

### hw/rtl/lphd_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on lphd_pkg for the payload types.
interface lphd_req_if import lphd_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lphd_rsp_if import lphd_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lphd_ram.sv
// Single-port-write, single-port-read synchronous memory for keys and values.
// Read data is registered and appears in the cycle after the address.
module lphd_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 96,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/lphd_hash.sv
// Iterative key hash: one key byte per cycle, then a bit-serial remainder
// of the 32-bit hash by the table size. Depends on lphd_pkg.
module lphd_hash import lphd_pkg::*; #(
  parameter int unsigned SLOTS  = SlotsDefault,
  localparam int unsigned IDX_W  = $clog2(SLOTS),
  localparam int unsigned SIZE_W = $clog2(SLOTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       key_i,
  input  logic [3:0]        len_i,
  input  logic [SIZE_W-1:0] size_i,
  output logic              done_o,
  output logic [IDX_W-1:0]  idx_o
);

  typedef enum logic [2:0] {
    H_IDLE = 3'b001,
    H_BYTE = 3'b010,
    H_MOD  = 3'b100
  } hstate_e;

  hstate_e           state_q, state_d;
  logic [63:0]       key_q, key_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [31:0]       h_q, h_d;
  logic [4:0]        bit_q, bit_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic              done_q, done_d;
  logic [SIZE_W:0]   r_next;

  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    cnt_d   = cnt_q;
    h_d     = h_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    r_next  = {rem_q, h_q[31]};
    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          key_d   = key_i;
          cnt_d   = len_i;
          h_d     = '0;
          bit_d   = '0;
          rem_d   = '0;
          state_d = (len_i == 4'd0) ? H_MOD : H_BYTE;
        end
      end
      H_BYTE: begin
        h_d   = h_q * HashMul + {24'd0, key_q[7:0]} + 32'd1;
        key_d = key_q >> 8;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          state_d = H_MOD;
        end
      end
      H_MOD: begin
        if (r_next >= {1'b0, size_i}) begin
          r_next = r_next - {1'b0, size_i};
        end
        rem_d = r_next[SIZE_W-1:0];
        h_d   = h_q << 1;
        bit_d = bit_q + 5'd1;
        if (bit_q == 5'd31) begin
          done_d  = 1'b1;
          state_d = H_IDLE;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cnt_q <= cnt_d;
    h_q   <= h_d;
    bit_q <= bit_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign idx_o  = rem_q[IDX_W-1:0];

endmodule

### hw/rtl/linear_probe_hash_dictionary.sv
// Top level of the linear probing hash dictionary.
// Depends on lphd_pkg, lphd_if, lphd_hash, lphd_ram and assert_macros.svh.
//
// Requests arrive on the req channel and each produces one transaction on
// the rsp channel. A request is taken only when the block is idle. The key
// is trimmed at its first zero byte, hashed one byte per cycle and reduced
// modulo the table size by a bit-serial remainder of the 32-bit hash. The
// probe then reads the key/value memory once per occupied slot, in a LOOK
// and a CMP state each, and ends at the first empty slot, on a matching key
// or after a full circle. Unused operation codes skip the hash and probe.
// A new request is taken only once the previous one has left S_DONE.
// The user must write table_size through cfg_we_i and cfg_wdata_i only while
// idle; the block does not enforce it. Sizes of zero act as one, sizes above
// SLOTS act as SLOTS. Reset clears every occupied mark at once and sets
// table_size to 251. A finished result waits in the rsp register while the
// receiver stalls, and the block may accept and process the next request
// meanwhile. That request holds its own result until the waiting one has left.
`include "assert_macros.svh"

module linear_probe_hash_dictionary import lphd_pkg::*; #(
  parameter int unsigned SLOTS     = SlotsDefault,
  parameter int unsigned KEY_BYTES = KeyBytesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [8:0]    cfg_wdata_i,
  lphd_req_if.sink      req,
  lphd_rsp_if.source    rsp
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned SIZE_W = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HASH = 5'b00010,
    S_LOOK = 5'b00100,
    S_CMP  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [8:0]        size_q;
  logic [SIZE_W-1:0] size_w;
  logic [1:0]        op_q, op_d;
  logic [63:0]       key_q, key_d;
  logic [31:0]       val_q, val_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SIZE_W-1:0] steps_q, steps_d;
  rsp_t              res_q, res_d;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_data_q, rsp_data_d;
  logic [SLOTS-1:0]  occ_q, occ_d;
  logic              req_fire;
  logic              hash_start, hash_done;
  logic [IDX_W-1:0]  hash_idx;
  logic [63:0]       trim_key;
  logic [3:0]        trim_len, len_lim;
  logic              alive;
  logic              mem_we;
  logic [95:0]       mem_rdata;
  logic [IDX_W-1:0]  idx_inc;

  always_comb begin
    if (size_q == 9'd0) begin
      size_w = SIZE_W'(1);
    end else if ({23'd0, size_q} > 32'(SLOTS)) begin
      size_w = SIZE_W'(SLOTS);
    end else begin
      size_w = SIZE_W'(size_q);
    end
  end

  always_comb begin
    trim_key = '0;
    trim_len = '0;
    alive    = 1'b1;
    len_lim  = (req.data.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req.data.key_length;
    for (int i = 0; i < 8; i++) begin
      if (alive && (4'(i) < len_lim) && (req.data.key[8*i +: 8] != 8'd0)) begin
        trim_key[8*i +: 8] = req.data.key[8*i +: 8];
        trim_len = trim_len + 4'd1;
      end else begin
        alive = 1'b0;
      end
    end
  end

  assign req.ready  = (state_q == S_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign hash_start = req_fire && (req.data.operation != OP_NONE);
  assign idx_inc    = ((SIZE_W'(idx_q) + SIZE_W'(1)) == size_w) ? '0 : idx_q + IDX_W'(1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    idx_d       = idx_q;
    steps_d     = steps_q;
    res_d       = res_q;
    occ_d       = occ_q;
    mem_we      = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp.ready;
    rsp_data_d  = rsp_data_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          op_d  = req.data.operation;
          key_d = trim_key;
          val_d = req.data.value;
          res_d = '{status: ST_NOT_FOUND, value_out: '0, slot: '0};
          state_d = (req.data.operation == OP_NONE) ? S_DONE : S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_d   = hash_idx;
          steps_d = '0;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!occ_q[idx_q]) begin
          if (op_q == OP_SET) begin
            mem_we       = 1'b1;
            occ_d[idx_q] = 1'b1;
            res_d.status = ST_OK;
            res_d.slot   = 8'(idx_q);
          end
          state_d = S_DONE;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (mem_rdata[95:32] == key_q) begin
          res_d.status = ST_OK;
          res_d.slot   = 8'(idx_q);
          case (op_q)
            OP_SET: begin
              mem_we = 1'b1;
            end
            OP_GET: begin
              res_d.value_out = mem_rdata[31:0];
            end
            default: begin
              occ_d[idx_q] = 1'b0;
            end
          endcase
          state_d = S_DONE;
        end else if ((steps_q + SIZE_W'(1)) == size_w) begin
          if (op_q == OP_SET) begin
            res_d.status = ST_FULL;
          end
          state_d = S_DONE;
        end else begin
          steps_d = steps_q + SIZE_W'(1);
          idx_d   = idx_inc;
          state_d = S_LOOK;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp.ready) begin
          rsp_valid_d = 1'b1;
          rsp_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= TableSizeReset;
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    idx_q      <= idx_d;
    steps_q    <= steps_d;
    res_q      <= res_d;
    rsp_data_q <= rsp_data_d;
  end

  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_data_q;

  lphd_hash #(
    .SLOTS (SLOTS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (trim_key),
    .len_i   (trim_len),
    .size_i  (size_w),
    .done_o  (hash_done),
    .idx_o   (hash_idx)
  );

  lphd_ram #(
    .DEPTH (SLOTS),
    .WIDTH (96)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i ({key_q, val_q}),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  `LPHD_ASSERT(a_idx_range, (state_q == S_LOOK) |-> (SIZE_W'(idx_q) < size_w), "probe index out of range")
  `LPHD_ASSERT(a_write_set, mem_we |-> (op_q == OP_SET), "memory written by a non-set request")
  `LPHD_ASSERT(a_cmp_after_look, (state_q == S_CMP) |-> ($past(state_q) == S_LOOK), "compare without a read")
  `LPHD_ASSERT_NEXT(a_done_loads, (state_q == S_DONE) && (!rsp_valid_q || rsp.ready), rsp_valid_q && (state_q == S_IDLE), "finished result not presented")

endmodule
